// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertions with an active-low reset that disables them
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, (ante) |-> (cons), msg)

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ----- hdl/tcemf_pkg.sv -----
// ----------------------------------------------------------------------------
// tcemf_pkg
// widths, fixed-point constants and the cell beat type of the type K
// emf to temperature converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcemf_pkg;

	localparam int unsigned SUM_W  = 16;
	localparam int unsigned CJ_W   = 16;
	localparam int unsigned REF_W  = 13;
	localparam int unsigned TEMP_W = 19;
	localparam int unsigned EMF_W  = 32;
	localparam int unsigned ACC_W  = 56;
	localparam int unsigned SPLIT_W = 32;
	localparam int unsigned N_CELLS = 9;

	localparam int unsigned SAMPLES_DEF  = 16;
	localparam int unsigned ADC_BITS_DEF = 12;

	localparam logic [REF_W-1:0] REF_RESET = 13'd3300;

	// gain 220 = 55 << 2
	localparam int unsigned EMF_FRAC = 27;
	localparam int unsigned PRE_SH   = 2;
	localparam int unsigned DIV_ODD  = 55;
	localparam int unsigned REM_W    = 6;
	localparam int unsigned P_W      = SUM_W + REF_W;
	localparam int unsigned Q1_W     = 24;
	localparam int unsigned AVG_SH   = 32;

	localparam int unsigned RECIP_Q1_SH = 35;
	localparam int unsigned RECIP_Q1_W  = 30;
	localparam logic [RECIP_Q1_W-1:0] RECIP_Q1 =
		RECIP_Q1_W'((64'd1 << RECIP_Q1_SH) / 64'(DIV_ODD) + 64'd1);

	localparam int unsigned RECIP_F_SH = 29;
	localparam int unsigned RECIP_F_W  = 24;
	localparam logic [RECIP_F_W-1:0] RECIP_F =
		RECIP_F_W'((64'd1 << RECIP_F_SH) / 64'(DIV_ODD) + 64'd1);

	// coefficient fraction bits
	localparam int unsigned FRAC1 = 42;
	localparam int unsigned FRAC2 = 49;
	localparam int unsigned FRAC3 = 48;
	localparam int unsigned FRAC4 = 50;
	localparam int unsigned FRAC5 = 53;
	localparam int unsigned FRAC6 = 56;
	localparam int unsigned FRAC7 = 61;
	localparam int unsigned FRAC8 = 66;
	localparam int unsigned FRAC9 = 73;
	localparam int unsigned TEMP_FRAC = 8;

	// rounded coefficient magnitudes
	localparam logic [63:0] CQ1 =
		(((64'd2508355 << 37) / 64'd3125) << 0) +
		((((64'd2508355 << 37) % 64'd3125) << 0) + 64'd3125 / 64'd2) / 64'd3125;
	localparam logic [63:0] CQ2 =
		(((64'd7860106 << 40) / 64'd390625) << 1) +
		((((64'd7860106 << 40) % 64'd390625) << 1) + 64'd390625 / 64'd2) / 64'd390625;
	localparam logic [63:0] CQ3 =
		(((64'd2503131 << 41) / 64'd78125) << 0) +
		((((64'd2503131 << 41) % 64'd78125) << 0) + 64'd78125 / 64'd2) / 64'd78125;
	localparam logic [63:0] CQ4 =
		(((64'd831527 << 43) / 64'd78125) << 0) +
		((((64'd831527 << 43) % 64'd78125) << 0) + 64'd78125 / 64'd2) / 64'd78125;
	localparam logic [63:0] CQ5 =
		(((64'd1228034 << 43) / 64'd390625) << 2) +
		((((64'd1228034 << 43) % 64'd390625) << 2) + 64'd390625 / 64'd2) / 64'd390625;
	localparam logic [63:0] CQ6 =
		(((64'd9804036 << 40) / 64'd9765625) << 6) +
		((((64'd9804036 << 40) % 64'd9765625) << 6) + 64'd9765625 / 64'd2) /
		64'd9765625;
	localparam logic [63:0] CQ7 =
		(((64'd441303 << 44) / 64'd9765625) << 7) +
		((((64'd441303 << 44) % 64'd9765625) << 7) + 64'd9765625 / 64'd2) /
		64'd9765625;
	localparam logic [63:0] CQ8 =
		(((64'd1057734 << 43) / 64'd244140625) << 11) +
		((((64'd1057734 << 43) % 64'd244140625) << 11) + 64'd244140625 / 64'd2) /
		64'd244140625;
	localparam logic [63:0] CQ9 =
		(((64'd1052755 << 43) / 64'd6103515625) << 16) +
		((((64'd1052755 << 43) % 64'd6103515625) << 16) + 64'd6103515625 / 64'd2) /
		64'd6103515625;

	localparam logic signed [ACC_W-1:0] C1 = ACC_W'(CQ1);
	localparam logic signed [ACC_W-1:0] C2 = ACC_W'(CQ2);
	localparam logic signed [ACC_W-1:0] C3 = ACC_W'(64'd0 - CQ3);
	localparam logic signed [ACC_W-1:0] C4 = ACC_W'(CQ4);
	localparam logic signed [ACC_W-1:0] C5 = ACC_W'(64'd0 - CQ5);
	localparam logic signed [ACC_W-1:0] C6 = ACC_W'(CQ6);
	localparam logic signed [ACC_W-1:0] C7 = ACC_W'(64'd0 - CQ7);
	localparam logic signed [ACC_W-1:0] C8 = ACC_W'(CQ8);
	localparam logic signed [ACC_W-1:0] C9 = ACC_W'(64'd0 - CQ9);

	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -19'sd10240;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 19'sd163840;

	typedef struct packed {
		logic signed [ACC_W-1:0] acc;
		logic        [EMF_W-1:0] emf;
		logic signed [CJ_W-1:0]  cj;
	} cell_data_t;

	// coefficient added by each cell, the last cell adds none
	function automatic logic signed [ACC_W-1:0] cell_coef(input int unsigned idx);
		logic signed [ACC_W-1:0] c;
		unique case (idx)
			0: c = C8;
			1: c = C7;
			2: c = C6;
			3: c = C5;
			4: c = C4;
			5: c = C3;
			6: c = C2;
			7: c = C1;
			default: c = '0;
		endcase
		return c;
	endfunction

	// product shift of each cell
	function automatic int unsigned cell_shift(input int unsigned idx);
		int unsigned s;
		unique case (idx)
			0: s = EMF_FRAC + FRAC9 - FRAC8;
			1: s = EMF_FRAC + FRAC8 - FRAC7;
			2: s = EMF_FRAC + FRAC7 - FRAC6;
			3: s = EMF_FRAC + FRAC6 - FRAC5;
			4: s = EMF_FRAC + FRAC5 - FRAC4;
			5: s = EMF_FRAC + FRAC4 - FRAC3;
			6: s = EMF_FRAC + FRAC3 - FRAC2;
			7: s = EMF_FRAC + FRAC2 - FRAC1;
			default: s = EMF_FRAC + FRAC1 - TEMP_FRAC;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/tcemf_scale.sv -----
// ----------------------------------------------------------------------------
// tcemf_scale
// averages the adc sum and scales it to a saturated q5.27 emf in mV
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcemf_scale import tcemf_pkg::*; #(
	parameter int unsigned SAMPLES  = SAMPLES_DEF,
	parameter int unsigned ADC_BITS = ADC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [SUM_W-1:0]        thermocouple_sum,
	input  logic signed [CJ_W-1:0]  cold_junction_temp,
	input  logic [REF_W-1:0]        adc_ref_millivolts,
	output logic                    out_valid,
	output cell_data_t              out_data
);

	localparam int unsigned AVG_W = AVG_SH + 1;
	localparam logic [AVG_W-1:0] AVG_MUL =
		AVG_W'((64'd1 << AVG_SH) / 64'(SAMPLES) + 64'd1);
	localparam int unsigned K = EMF_FRAC - PRE_SH - ADC_BITS;
	localparam int unsigned RS_W = REM_W + K;
	localparam logic [P_W-1:0] SAT_P = P_W'(64'(DIV_ODD) << (EMF_W - K));

	logic [SUM_W+AVG_W-1:0]        prod_avg;
	logic [SUM_W+AVG_W-1:0]        prod_avg_s1;
	logic [SUM_W-1:0]              avg;
	logic [P_W-1:0]                p_s2, p_s3;
	logic [P_W+RECIP_Q1_W-1:0]     prod_q1;
	logic [Q1_W-1:0]               q1_s3, q1_s4;
	logic                          sat_s3, sat_s4;
	logic [P_W-1:0]                rem_full;
	logic [REM_W-1:0]              r_s4;
	logic [RS_W-1:0]               rs;
	logic [RS_W+RECIP_F_W-1:0]     prod_f;
	logic [K-1:0]                  f;
	logic [Q1_W+K-1:0]             emf_full;
	logic [EMF_W-1:0]              emf;
	logic signed [CJ_W-1:0]        cj_s1, cj_s2, cj_s3, cj_s4;
	logic                          v_s1, v_s2, v_s3, v_s4, v_s5;
	cell_data_t                    data_s5;

	// floor division by samples through a reciprocal
	assign prod_avg = (SUM_W+AVG_W)'(thermocouple_sum) * (SUM_W+AVG_W)'(AVG_MUL);
	assign avg      = prod_avg_s1[AVG_SH +: SUM_W];

	// p = 55 * q1 + r
	assign prod_q1  = (P_W+RECIP_Q1_W)'(p_s2) * (P_W+RECIP_Q1_W)'(RECIP_Q1);
	assign rem_full = p_s3 - P_W'(q1_s3) * P_W'(DIV_ODD);

	// emf = q1 * 2^k + floor(r * 2^k / 55)
	assign rs       = {r_s4, {K{1'b0}}};
	assign prod_f   = (RS_W+RECIP_F_W)'(rs) * (RS_W+RECIP_F_W)'(RECIP_F);
	assign f        = prod_f[RECIP_F_SH +: K];
	assign emf_full = {q1_s4, f};
	assign emf      = sat_s4 ? '1 : emf_full[EMF_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_avg_s1  <= prod_avg;
			cj_s1        <= cold_junction_temp;
			p_s2         <= P_W'(avg) * P_W'(adc_ref_millivolts);
			cj_s2        <= cj_s1;
			q1_s3        <= prod_q1[RECIP_Q1_SH +: Q1_W];
			p_s3         <= p_s2;
			sat_s3       <= p_s2 >= SAT_P;
			cj_s3        <= cj_s2;
			r_s4         <= rem_full[REM_W-1:0];
			q1_s4        <= q1_s3;
			sat_s4       <= sat_s3;
			cj_s4        <= cj_s3;
			data_s5.acc  <= C9;
			data_s5.emf  <= emf;
			data_s5.cj   <= cj_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = data_s5;

endmodule

`default_nettype wire

// ----- hdl/tcemf_cell.sv -----
// ----------------------------------------------------------------------------
// tcemf_cell
// one horner step: acc <= coef + floor(acc * emf / 2^shift), two stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcemf_cell import tcemf_pkg::*; #(
	parameter int unsigned             SHIFT = EMF_FRAC,
	parameter logic signed [ACC_W-1:0] COEF  = '0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_valid,
	input  cell_data_t in_data,
	output logic       out_valid,
	output cell_data_t out_data
);

	localparam int unsigned HI_W   = ACC_W - SPLIT_W;
	localparam int unsigned PH_W   = HI_W + EMF_W + 1;
	localparam int unsigned PL_W   = SPLIT_W + EMF_W;
	localparam int unsigned FULL_W = ACC_W + EMF_W + 1;

	logic signed [PH_W-1:0]   ph, ph_s1;
	logic [PL_W-1:0]          pl, pl_s1;
	logic [EMF_W-1:0]         emf_s1;
	logic signed [CJ_W-1:0]   cj_s1;
	logic signed [FULL_W-1:0] full;
	logic signed [FULL_W-1:0] shifted;
	logic                     v_s1, v_s2;
	cell_data_t               data_s2;

	// split product: signed upper part and unsigned lower word
	assign ph = PH_W'($signed(in_data.acc[ACC_W-1:SPLIT_W])) *
		PH_W'($signed({1'b0, in_data.emf}));
	assign pl = PL_W'(in_data.acc[SPLIT_W-1:0]) * PL_W'(in_data.emf);

	assign full    = (FULL_W'(ph_s1) <<< SPLIT_W) + FULL_W'(pl_s1);
	assign shifted = full >>> SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1       <= ph;
			pl_s1       <= pl;
			emf_s1      <= in_data.emf;
			cj_s1       <= in_data.cj;
			data_s2.acc <= COEF + shifted[ACC_W-1:0];
			data_s2.emf <= emf_s1;
			data_s2.cj  <= cj_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = data_s2;

endmodule

`default_nettype wire

// ----- hdl/thermocouple_emf_to_temperature.sv -----
// ----------------------------------------------------------------------------
// thermocouple_emf_to_temperature
// type k thermocouple reading to cold-junction compensated temperature
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one beat of thermocouple_sum and
//   cold_junction_temp. Output channel out_valid/out_ready carries one beat of
//   temperature in 1/256 degC, clamped to [-10240, 163840].
//   cfg_wr_en/cfg_wr_data write the adc reference in mV; write only while
//   the pipe is empty.
//   An input beat passes the emf scaling stages, then 9 horner cells, then
//   the clamp register. Throughput is one beat per cycle unless the pipe
//   holds: each cell owns one coefficient and one split 56x32 multiply and
//   hands its accumulator to the next cell.
//   When out_ready is low with a result waiting, the whole pipe holds and
//   in_ready drops in the same cycle; everything moves again with out_ready.
//   Reset empties the pipe and loads the reference with 3300 mV.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thermocouple_emf_to_temperature import tcemf_pkg::*; #(
	parameter int unsigned SAMPLES  = SAMPLES_DEF,
	parameter int unsigned ADC_BITS = ADC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [REF_W-1:0]         cfg_wr_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [SUM_W-1:0]         thermocouple_sum,
	input  logic signed [CJ_W-1:0]   cold_junction_temp,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [TEMP_W-1:0] temperature
);

	logic                     adv;
	logic [REF_W-1:0]         ref_q;
	logic                     chain_v [N_CELLS+1];
	cell_data_t               chain_d [N_CELLS+1];
	logic signed [ACC_W:0]    tsum;
	logic signed [ACC_W:0]    tclamp;
	logic                     out_valid_q;
	logic signed [TEMP_W-1:0] temperature_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= REF_RESET;
		end else if (cfg_wr_en) begin
			ref_q <= cfg_wr_data;
		end
	end

	tcemf_scale #(
		.SAMPLES  (SAMPLES),
		.ADC_BITS (ADC_BITS)
	) u_scale (
		.clk                (clk),
		.arst_n             (arst_n),
		.en                 (adv),
		.in_valid           (in_valid),
		.thermocouple_sum   (thermocouple_sum),
		.cold_junction_temp (cold_junction_temp),
		.adc_ref_millivolts (ref_q),
		.out_valid          (chain_v[0]),
		.out_data           (chain_d[0])
	);

	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		tcemf_cell #(
			.SHIFT (cell_shift(i)),
			.COEF  (cell_coef(i))
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (chain_v[i]),
			.in_data   (chain_d[i]),
			.out_valid (chain_v[i+1]),
			.out_data  (chain_d[i+1])
		);
	end

	assign tsum = (ACC_W+1)'(chain_d[N_CELLS].acc) + (ACC_W+1)'(chain_d[N_CELLS].cj);

	always_comb begin
		priority if (tsum < TEMP_MIN) begin
			tclamp = (ACC_W+1)'(TEMP_MIN);
		end else if (tsum > TEMP_MAX) begin
			tclamp = (ACC_W+1)'(TEMP_MAX);
		end else begin
			tclamp = tsum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain_v[N_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			temperature_q <= tclamp[TEMP_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign temperature = temperature_q;

endmodule

`default_nettype wire

// ----- hdl/tcemf_checker.sv -----
// ----------------------------------------------------------------------------
// tcemf_checker
// port-level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tcemf_checker import tcemf_pkg::*; (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_ready,
	input wire logic                     out_valid,
	input wire logic                     out_ready,
	input wire logic signed [TEMP_W-1:0] temperature
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "out beat dropped")
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(temperature), "out beat changed")
	`ASSERT_IMPL(a_out_range, clk, arst_n, out_valid, (temperature >= TEMP_MIN) && (temperature <= TEMP_MAX), "temperature out of range")
	`ASSERT_IMPL(a_stall_backpressure, clk, arst_n, out_valid && !out_ready, !in_ready, "input taken while stalled")

endmodule

bind thermocouple_emf_to_temperature tcemf_checker u_tcemf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.temperature (temperature)
);

`default_nettype wire
